@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define RHD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hazard detector assertion failed");

// clocked assertion that also holds during reset
`define RHD_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("hazard detector assertion failed during reset");

`endif

@@ rtl/core/rhd_pkg.sv @@
package rhd_pkg;

	localparam int NUM_REGS     = 32;
	localparam int INDEX_BITS   = 16;
	localparam int REG_BITS     = 5;
	localparam int REG_IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int NUM_SLOTS    = 3;
	localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
	localparam int FIFO_DEPTH   = 2;

	typedef enum logic [1:0] {
		CLS_R     = 2'd0,
		CLS_I     = 2'd1,
		CLS_J     = 2'd2,
		CLS_OTHER = 2'd3
	} inst_class_t;

	typedef enum logic [1:0] {
		ACC_NONE  = 2'd0,
		ACC_READ  = 2'd1,
		ACC_WRITE = 2'd2
	} access_t;

	typedef enum logic [1:0] {
		HZ_RAW = 2'd0,
		HZ_WAR = 2'd1,
		HZ_WAW = 2'd2
	} hazard_t;

	typedef logic [REG_BITS-1:0]   reg_num_t;
	typedef logic [INDEX_BITS-1:0] index_t;

	typedef struct packed {
		inst_class_t inst_class;
		reg_num_t    src_reg_s;
		reg_num_t    src_reg_t;
		reg_num_t    dest_reg_d;
		logic        uses_s;
		logic        uses_t;
		logic        uses_d;
	} inst_t;

	typedef struct packed {
		hazard_t  hazard_kind;
		reg_num_t hazard_reg;
		index_t   earlier_index;
		index_t   later_index;
		logic     last_of_item;
	} rec_t;

	// one record moving between the front, the queue and the output stage
	typedef struct packed {
		logic valid;
		rec_t rec;
	} rec_beat_t;

endpackage

@@ rtl/core/rhd_front.sv @@
module rhd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              inst_valid,
	output logic              inst_ready,
	input  rhd_pkg::inst_t    inst,
	output rhd_pkg::rec_beat_t push,
	input  logic              q_full
);
	import rhd_pkg::*;

	// slot 1 is the write access, slots 0 and 2 are reads
	localparam logic [NUM_SLOTS-1:0] SLOT_WRITE = 3'b010;

	access_t  kind_q     [NUM_REGS];
	index_t   last_idx_q [NUM_REGS];
	index_t   count_q;

	index_t                cur_s1;
	reg_num_t              slot_reg_s1 [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  mask_s1;

	rec_t held_q;
	logic held_v_q;
	logic held_done_q;

	logic [NUM_SLOTS-1:0]    dec_mask;
	logic [NUM_SLOTS-1:0]    sel_oh;
	logic [NUM_SLOTS-1:0]    mask_next;
	logic [SLOT_BITS-1:0]    sel;
	logic [REG_IDX_BITS-1:0] ti;
	reg_num_t                sel_reg;
	logic                    sel_wr;
	access_t                 prev;
	rec_t                    new_rec;
	logic busy, hit, push_need, stall, step, last_step, accept;

	function automatic logic in_range(reg_num_t r);
		return int'(r) < NUM_REGS;
	endfunction

	// decode the accesses this instruction makes
	always_comb begin
		dec_mask[0] = (inst.inst_class == CLS_R || inst.inst_class == CLS_I)
			&& inst.uses_s && in_range(inst.src_reg_s);
		dec_mask[1] = (inst.inst_class == CLS_R && inst.uses_d && in_range(inst.dest_reg_d))
			|| (inst.inst_class == CLS_I && inst.uses_t && in_range(inst.src_reg_t));
		dec_mask[2] = inst.inst_class == CLS_R && inst.uses_t && in_range(inst.src_reg_t);
	end

	// pick the lowest pending access
	always_comb begin
		sel    = '0;
		sel_oh = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				sel    = SLOT_BITS'(i);
				sel_oh = NUM_SLOTS'(1) << i;
			end
		end
	end

	always_comb begin
		busy      = |mask_s1;
		sel_reg   = slot_reg_s1[sel];
		sel_wr    = SLOT_WRITE[sel];
		ti        = REG_IDX_BITS'(sel_reg);
		prev      = kind_q[ti];
		hit       = busy && (prev == ACC_WRITE || (prev == ACC_READ && sel_wr));

		new_rec.hazard_kind   = (prev == ACC_WRITE) ? (sel_wr ? HZ_WAW : HZ_RAW) : HZ_WAR;
		new_rec.hazard_reg    = sel_reg;
		new_rec.earlier_index = last_idx_q[ti];
		new_rec.later_index   = cur_s1;
		new_rec.last_of_item  = 1'b0;

		// the held record leaves once the next one is known or its item is done
		push_need = held_v_q && (held_done_q || hit);
		stall     = push_need && q_full;
		step      = busy && !stall;
		mask_next = mask_s1 & ~sel_oh;
		last_step = step && (mask_next == '0);

		inst_ready = !busy || last_step;
		accept     = inst_valid && inst_ready;

		push.valid            = push_need && !stall;
		push.rec              = held_q;
		push.rec.last_of_item = held_done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				kind_q[i] <= ACC_NONE;
			end
			count_q     <= '0;
			mask_s1     <= '0;
			held_v_q    <= 1'b0;
			held_done_q <= 1'b0;
		end else begin
			if (step) begin
				kind_q[ti] <= sel_wr ? ACC_WRITE : ACC_READ;
			end
			if (accept) begin
				mask_s1 <= dec_mask;
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end else if (step) begin
				mask_s1 <= mask_next;
			end
			if (!stall) begin
				if (hit) begin
					held_v_q    <= 1'b1;
					held_done_q <= last_step;
				end else if (push_need) begin
					held_v_q    <= 1'b0;
					held_done_q <= 1'b0;
				end else if (last_step && held_v_q) begin
					held_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			last_idx_q[ti] <= cur_s1;
		end
		if (hit && !stall) begin
			held_q <= new_rec;
		end
		if (accept) begin
			cur_s1         <= count_q;
			slot_reg_s1[0] <= inst.src_reg_s;
			slot_reg_s1[1] <= (inst.inst_class == CLS_R) ? inst.dest_reg_d : inst.src_reg_t;
			slot_reg_s1[2] <= inst.src_reg_t;
		end
	end

endmodule

@@ rtl/core/rhd_fifo.sv @@
module rhd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  rhd_pkg::rec_beat_t push,
	output logic               full,
	output rhd_pkg::rec_beat_t head,
	input  logic               pop
);
	import rhd_pkg::*;

	localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

	rec_t                mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	function automatic logic [PTR_BITS-1:0] ptr_inc(logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		full       = count_q == CNT_BITS'(FIFO_DEPTH);
		head.valid = count_q != '0;
		head.rec   = mem_q[rd_ptr_q];
		do_push    = push.valid && !full;
		do_pop     = pop && head.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

endmodule

@@ rtl/core/rhd_back.sv @@
module rhd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rhd_pkg::rec_beat_t head,
	output logic               pop,
	output logic               rec_valid,
	input  logic               rec_ready,
	output rhd_pkg::rec_t      rec
);
	import rhd_pkg::*;

	logic out_v_q;
	rec_t out_q;

	always_comb begin
		pop       = head.valid && (!out_v_q || rec_ready);
		rec_valid = out_v_q;
		rec       = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (rec_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head.rec;
		end
	end

endmodule

@@ rtl/core/register_hazard_detector_top.sv @@
// a record passes the front's held record register and the queue before the output register
// throughput: one register access (rs, rd, rt) checked per cycle while the queue is not full;
//   a new instruction is taken at the last check; one record leaves per cycle while rec_ready
// the access-kind table is a flip-flop array read and updated at one register per unstalled cycle
// reset: arst_n clears the access-kind table, the instruction counter, the queue and the output
//   valid at once; the last-index table is not cleared and is read only after a write
module register_hazard_detector_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           inst_valid,
	output logic           inst_ready,
	input  rhd_pkg::inst_t inst,
	output logic           rec_valid,
	input  logic           rec_ready,
	output rhd_pkg::rec_t  rec
);
	import rhd_pkg::*;

	// front to queue: one record beat per cycle at most
	rec_beat_t push;
	logic      q_full;
	// queue to output stage
	rec_beat_t head;
	logic      pop;

	// front: takes instructions, walks their accesses against the
	// per-register table, holds back one record so the last of an
	// instruction can be marked before it goes out
	rhd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.inst_valid (inst_valid),
		.inst_ready (inst_ready),
		.inst       (inst),
		.push       (push),
		.q_full     (q_full)
	);

	// short record queue so the front keeps running while the sink stalls
	rhd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// back: registered output beat
	rhd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

endmodule

@@ rtl/core/rhd_checker.sv @@
`include "assert_macros.svh"

module rhd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rec_valid,
	input logic          rec_ready,
	input rhd_pkg::rec_t rec
);
	import rhd_pkg::*;

	// a stalled record beat holds
	`RHD_ASSERT(a_rec_hold, clk, arst_n, rec_valid && !rec_ready |=> rec_valid && $stable(rec))

	// the earlier access never comes from a later instruction
	`RHD_ASSERT(a_idx_order, clk, arst_n, rec_valid |-> rec.earlier_index <= rec.later_index)

	// records leave in instruction order
	`RHD_ASSERT(a_later_mono, clk, arst_n, rec_valid && rec_ready |=> !rec_valid || rec.later_index >= $past(rec.later_index))

	// nothing is offered while in reset
	`RHD_ASSERT_NR(a_rst_idle, clk, !arst_n |-> !rec_valid)

endmodule

bind register_hazard_detector_top rhd_checker u_rhd_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rhd_pkg::*;

	// predicts the hazard records of each instruction beat and holds them until they come out
	class hazard_scoreboard;
		access_t kind_tab[NUM_REGS];
		index_t  last_idx[NUM_REGS];
		index_t  next_index;
		rec_t    item_recs[$];
		rec_t    pending_hazards[$];
		int      fail_count;

		function new();
			foreach (kind_tab[r]) begin
				kind_tab[r] = ACC_NONE;
				last_idx[r] = '0;
			end
			next_index = '0;
			fail_count = 0;
		endfunction

		// one register access: record against the previous access, then update the entry
		function void access_reg(reg_num_t r, bit is_write, index_t cur);
			rec_t h;
			if (int'(r) >= NUM_REGS)
				return;
			h = '0;
			h.hazard_reg    = r;
			h.earlier_index = last_idx[r];
			h.later_index   = cur;
			h.last_of_item  = 1'b0;
			if (kind_tab[r] == ACC_WRITE) begin
				h.hazard_kind = is_write ? HZ_WAW : HZ_RAW;
				item_recs = {item_recs, h};
			end else if (kind_tab[r] == ACC_READ && is_write) begin
				h.hazard_kind = HZ_WAR;
				item_recs = {item_recs, h};
			end
			last_idx[r] = cur;
			kind_tab[r] = is_write ? ACC_WRITE : ACC_READ;
		endfunction

		function void note_inst(inst_t i);
			index_t cur;
			cur = next_index;
			item_recs.delete();
			case (i.inst_class)
				CLS_R: begin
					if (i.uses_s) access_reg(i.src_reg_s, 1'b0, cur);
					if (i.uses_d) access_reg(i.dest_reg_d, 1'b1, cur);
					if (i.uses_t) access_reg(i.src_reg_t, 1'b0, cur);
				end
				CLS_I: begin
					if (i.uses_s) access_reg(i.src_reg_s, 1'b0, cur);
					if (i.uses_t) access_reg(i.src_reg_t, 1'b1, cur);
				end
				default: ;
			endcase
			if (item_recs.size() > 0)
				item_recs[item_recs.size()-1].last_of_item = 1'b1;
			foreach (item_recs[k])
				pending_hazards = {pending_hazards, item_recs[k]};
			// counter sticks at its maximum
			if (cur != '1)
				next_index = cur + 1'b1;
		endfunction

		task log_mismatch(string msg);
			$display("mismatch: %s", msg);
			fail_count++;
		endtask

		task check_rec(rec_t got);
			rec_t want;
			if (pending_hazards.size() == 0) begin
				log_mismatch($sformatf("unexpected record kind %0d reg %0d idx %0d/%0d",
					got.hazard_kind, got.hazard_reg, got.earlier_index, got.later_index));
				return;
			end
			want = pending_hazards.pop_front();
			if (got.hazard_kind != want.hazard_kind)
				log_mismatch($sformatf("hazard_kind got %0d want %0d (later %0d)",
					got.hazard_kind, want.hazard_kind, want.later_index));
			if (got.hazard_reg != want.hazard_reg)
				log_mismatch($sformatf("hazard_reg got %0d want %0d (later %0d)",
					got.hazard_reg, want.hazard_reg, want.later_index));
			if (got.earlier_index != want.earlier_index)
				log_mismatch($sformatf("earlier_index got %0d want %0d (later %0d)",
					got.earlier_index, want.earlier_index, want.later_index));
			if (got.later_index != want.later_index)
				log_mismatch($sformatf("later_index got %0d want %0d",
					got.later_index, want.later_index));
			if (got.last_of_item != want.last_of_item)
				log_mismatch($sformatf("last_of_item got %0d want %0d (later %0d)",
					got.last_of_item, want.last_of_item, want.later_index));
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  inst_valid = 1'b0;
	logic  inst_ready;
	inst_t inst       = '0;
	logic  rec_valid;
	logic  rec_ready  = 1'b0;
	rec_t  rec;

	hazard_scoreboard sb = new();

	// sender burst state and the register window that random beats favor
	int burst_left = 0;
	int hot_base   = 0;

	register_hazard_detector_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.inst_valid(inst_valid),
		.inst_ready(inst_ready),
		.inst      (inst),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function automatic inst_t make_inst(inst_class_t cls, int s, int t, int d,
			bit us, bit ut, bit ud);
		inst_t i;
		i.inst_class = cls;
		i.src_reg_s  = reg_num_t'(s);
		i.src_reg_t  = reg_num_t'(t);
		i.dest_reg_d = reg_num_t'(d);
		i.uses_s     = us;
		i.uses_t     = ut;
		i.uses_d     = ud;
		return i;
	endfunction

	// mostly a small window of registers so that dependences pile up
	function automatic reg_num_t pick_reg();
		if ($urandom_range(0, 9) < 7)
			return reg_num_t'(hot_base + $urandom_range(0, 3));
		return reg_num_t'($urandom_range(0, 31));
	endfunction

	function automatic inst_t rand_inst();
		int r;
		inst_class_t cls;
		r = $urandom_range(0, 99);
		if (r < 45)
			cls = CLS_R;
		else if (r < 85)
			cls = CLS_I;
		else if (r < 93)
			cls = CLS_J;
		else
			cls = CLS_OTHER;
		return make_inst(cls, pick_reg(), pick_reg(), pick_reg(),
			$urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85,
			$urandom_range(0, 99) < 85);
	endfunction

	// hold one instruction beat until it is taken, then hand it to the predictor
	task automatic send_inst(inst_t i);
		inst       <= i;
		inst_valid <= 1'b1;
		do @(posedge clk); while (!inst_ready);
		sb.note_inst(i);
	endtask

	// bursts of random length, with a random gap (sometimes none) between them
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			hot_base   = $urandom_range(0, 28);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				inst_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// result side: check each record beat, stall on a rotating pattern redrawn now and then
	initial begin
		logic [15:0] stall_pat;
		int          pat_left;
		stall_pat = '1;
		pat_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rec_valid && rec_ready)
				sb.check_rec(rec);
			if (pat_left == 0) begin
				pat_left = 32;
				case ($urandom_range(0, 3))
					0: stall_pat = '1;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom) & 16'($urandom);
					default: stall_pat = 16'($urandom) | 16'($urandom);
				endcase
			end
			rec_ready <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			pat_left--;
		end
	end

	initial begin
		inst_t dir_q[$];
		int    waited;

		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first touch of rs, rd, rt: nothing reported
		dir_q = {dir_q, make_inst(CLS_R, 1, 3, 2, 1, 1, 1)};
		// raw on r2, war on r1, read after read on r3
		dir_q = {dir_q, make_inst(CLS_R, 2, 3, 1, 1, 1, 1)};
		// i-type writing the register it just read: war against itself
		dir_q = {dir_q, make_inst(CLS_I, 5, 5, 9, 1, 1, 0)};
		// rs == rd == rt on a fresh register: war on itself, then raw on itself
		dir_q = {dir_q, make_inst(CLS_R, 7, 7, 7, 1, 1, 1)};
		// read after read on r7, war on r2
		dir_q = {dir_q, make_inst(CLS_I, 7, 2, 0, 1, 1, 0)};
		// lone write: waw on r2
		dir_q = {dir_q, make_inst(CLS_R, 0, 0, 2, 0, 0, 1)};
		// j-type and other classes make no access at all
		dir_q = {dir_q, make_inst(CLS_J, 31, 31, 31, 1, 1, 1)};
		dir_q = {dir_q, make_inst(CLS_OTHER, 31, 31, 31, 1, 1, 1)};
		dir_q = {dir_q, make_inst(CLS_R, 7, 7, 7, 0, 0, 0)};
		dir_q = {dir_q, make_inst(CLS_I, 7, 7, 0, 0, 0, 1)};
		// extremes of the register numbers
		dir_q = {dir_q, make_inst(CLS_R, 0, 31, 31, 1, 1, 1)};
		dir_q = {dir_q, make_inst(CLS_I, 31, 0, 31, 1, 1, 1)};
		dir_q = {dir_q, make_inst(CLS_I, 0, 31, 0, 0, 1, 0)};
		dir_q = {dir_q, make_inst(CLS_R, 31, 0, 0, 1, 0, 1)};
		dir_q = {dir_q, make_inst(CLS_R, 0, 0, 0, 1, 1, 1)};
		// only the rt read of an r-type
		dir_q = {dir_q, make_inst(CLS_R, 5, 5, 5, 0, 1, 0)};
		// all ones and all zeros beats
		dir_q = {dir_q, inst_t'('1)};
		dir_q = {dir_q, inst_t'('0)};
		dir_q = {dir_q, make_inst(CLS_R, 31, 31, 0, 1, 1, 1)};

		foreach (dir_q[k]) begin
			send_inst(dir_q[k]);
			pace();
		end

		repeat (450) begin
			send_inst(rand_inst());
			pace();
		end
		inst_valid <= 1'b0;

		waited = 0;
		while (sb.pending_hazards.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending_hazards.size() != 0)
			sb.log_mismatch($sformatf("%0d records never came out",
				sb.pending_hazards.size()));

		if (sb.fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rhd_pkg.sv
rtl/core/rhd_front.sv
rtl/core/rhd_fifo.sv
rtl/core/rhd_back.sv
rtl/core/register_hazard_detector_top.sv
rtl/core/rhd_checker.sv
test/tb_top.sv
